### hw/rtl/mmlb_pkg.sv
// ============================================================================
// mmlb_pkg
// Shared types, codes and helpers for the mouse motion latch bridge.
// ============================================================================
package mmlb_pkg;

	// Command codes of one input item.
	typedef enum logic [1:0] {
		CMD_REPORT = 2'd0,
		CMD_LATCH  = 2'd1,
		CMD_TICK   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	// One input item.
	typedef struct packed {
		logic [1:0]        command;
		logic [7:0]        button_bits;
		logic signed [7:0] move_x;
		logic signed [7:0] move_y;
	} event_t;

	// One result item.
	typedef struct packed {
		logic [31:0] report_word;
		logic        push_now;
	} result_t;

	localparam logic [7:0]  WORD_TAG      = 8'h2F;
	localparam logic [15:0] PERIOD_RESET  = 16'd7000;
	localparam logic [7:0]  BUTTONS_RESET = 8'hFF;
	localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

	// The host word: tag, buttons, then bits 8..1 of the complemented motion.
	function automatic logic [31:0] form_word(input logic [7:0] buttons,
		input logic [15:0] x, input logic [15:0] y);
		logic [15:0] nx;
		logic [15:0] ny;
		nx = ~x;
		ny = ~y;
		return {WORD_TAG, buttons, nx[8:1], ny[8:1]};
	endfunction

endpackage

### hw/rtl/mouse_motion_latch_bridge.sv
// ============================================================================
// mouse_motion_latch_bridge
// Gathers mouse motion and hands a latched 32-bit word to a host shifter.
// ============================================================================
// Each accepted item (mouse report, host latch edge or microsecond tick)
// produces exactly one result item, which passes through the input register
// and the result register to the result port. A new item can be taken in
// every cycle unless the result side stalls. An item sits in the input
// register, the state and the result are updated together as it moves into
// the result register, so the sustained rate is one item per clock; it is
// limited only by stall on the result side. The release period register is
// written through its own port, which is always ready.
module mouse_motion_latch_bridge (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  event_valid,
	output logic                  event_stall,
	input  mmlb_pkg::event_t      event_item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output mmlb_pkg::result_t     result_item,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [15:0]           cfg_data
);

	// Pipeline registers.
	logic              valid_s1;
	mmlb_pkg::event_t  item_s1;
	logic              valid_s2;
	mmlb_pkg::result_t item_s2;

	// Block state.
	logic [15:0] period_q;
	logic [15:0] acc_x_q, acc_y_q, held_x_q, held_y_q;
	logic [7:0]  live_buttons_q, held_buttons_q;
	logic        scan_lock_q, scan_seen_q;
	logic [15:0] elapsed_q;

	// Next-state values for the item in the input register.
	logic [15:0] acc_x_d, acc_y_d, held_x_d, held_y_d;
	logic [7:0]  live_buttons_d, held_buttons_d;
	logic        scan_lock_d, scan_seen_d;
	logic [15:0] elapsed_d;
	logic [15:0] elapsed_inc;
	logic [15:0] sum_x, sum_y;
	logic [31:0] word_now;
	mmlb_pkg::result_t result_d;

	logic advance;

	// The input register moves on whenever the result register is free or drains.
	assign advance     = valid_s1 && (!valid_s2 || !result_stall);
	assign event_stall = valid_s1 && valid_s2 && result_stall;
	assign cfg_ready   = 1'b1;

	assign result_valid = valid_s2;
	assign result_item  = item_s2;

	// The current word always follows the held values.
	assign word_now = mmlb_pkg::form_word(held_buttons_q, held_x_q, held_y_q);
	assign sum_x    = acc_x_q + {{8{item_s1.move_x[7]}}, item_s1.move_x};
	assign sum_y    = acc_y_q + {{8{item_s1.move_y[7]}}, item_s1.move_y};
	assign elapsed_inc = (elapsed_q == mmlb_pkg::ELAPSED_MAX) ? elapsed_q
		: elapsed_q + 16'd1;

	// Per-command state update and result.
	always_comb begin
		acc_x_d        = acc_x_q;
		acc_y_d        = acc_y_q;
		held_x_d       = held_x_q;
		held_y_d       = held_y_q;
		live_buttons_d = live_buttons_q;
		held_buttons_d = held_buttons_q;
		scan_lock_d    = scan_lock_q;
		scan_seen_d    = scan_seen_q;
		elapsed_d      = elapsed_q;
		result_d.report_word = word_now;
		result_d.push_now    = 1'b0;
		unique case (mmlb_pkg::cmd_t'(item_s1.command))
			mmlb_pkg::CMD_REPORT: begin
				acc_x_d        = sum_x;
				acc_y_d        = sum_y;
				live_buttons_d = item_s1.button_bits;
				if (!scan_lock_q) begin
					held_x_d       = sum_x;
					held_y_d       = sum_y;
					held_buttons_d = item_s1.button_bits;
					result_d.report_word = mmlb_pkg::form_word(item_s1.button_bits,
						sum_x, sum_y);
				end
			end
			mmlb_pkg::CMD_LATCH: begin
				if (!scan_lock_q) begin
					scan_lock_d       = 1'b1;
					scan_seen_d       = 1'b1;
					elapsed_d         = '0;
					result_d.push_now = 1'b1;
				end
			end
			mmlb_pkg::CMD_TICK: begin
				elapsed_d = elapsed_inc;
				if (elapsed_inc > period_q) begin
					// The word pushed is the one formed before motion is consumed.
					result_d.push_now = 1'b1;
					if (scan_seen_q) begin
						acc_x_d        = acc_x_q - held_x_q;
						acc_y_d        = acc_y_q - held_y_q;
						held_x_d       = '0;
						held_y_d       = '0;
						held_buttons_d = live_buttons_q;
						scan_seen_d    = 1'b0;
					end
					scan_lock_d = 1'b0;
					elapsed_d   = '0;
				end
			end
			mmlb_pkg::CMD_NONE: begin
				result_d.push_now = 1'b0;
			end
		endcase
	end

	// Control and block state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			period_q       <= mmlb_pkg::PERIOD_RESET;
			acc_x_q        <= '0;
			acc_y_q        <= '0;
			held_x_q       <= '0;
			held_y_q       <= '0;
			live_buttons_q <= mmlb_pkg::BUTTONS_RESET;
			held_buttons_q <= mmlb_pkg::BUTTONS_RESET;
			scan_lock_q    <= 1'b0;
			scan_seen_q    <= 1'b0;
			elapsed_q      <= '0;
		end else begin
			if (event_valid && !event_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!result_stall) begin
				valid_s2 <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				period_q <= cfg_data;
			end
			if (advance) begin
				acc_x_q        <= acc_x_d;
				acc_y_q        <= acc_y_d;
				held_x_q       <= held_x_d;
				held_y_q       <= held_y_d;
				live_buttons_q <= live_buttons_d;
				held_buttons_q <= held_buttons_d;
				scan_lock_q    <= scan_lock_d;
				scan_seen_q    <= scan_seen_d;
				elapsed_q      <= elapsed_d;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (event_valid && !event_stall) begin
			item_s1 <= event_item;
		end
		if (advance) begin
			item_s2 <= result_d;
		end
	end

endmodule

### hw/rtl/mmlb_checker.sv
// ============================================================================
// mmlb_checker
// Port-level checks for the mouse motion latch bridge.
// ============================================================================
module mmlb_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              event_valid,
	input logic              event_stall,
	input logic              result_valid,
	input logic              result_stall,
	input mmlb_pkg::result_t result_item
);

	// A stalled result item stays and holds its value.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_item))
		else $error("result item changed while stalled");

	// Every word shown carries the fixed tag in its top byte.
	a_word_tag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_item.report_word[31:24] == mmlb_pkg::WORD_TAG)
		else $error("report word lost its tag");

	// The input side is held back only by a stalled result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		event_stall |-> result_valid && result_stall)
		else $error("input stalled without a stalled result");

	// An accepted item always yields a valid result once it has passed the input register.
	a_item_result: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && !event_stall |=> ##1 result_valid)
		else $error("accepted item produced no result");

endmodule

bind mouse_motion_latch_bridge mmlb_checker u_mmlb_checker (.*);

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the mouse motion latch bridge
// Sends mouse reports, host latch edges, microsecond ticks and unused codes
// through the valid/stall event channel, and rewrites the release period
// between phases. A built-in predictor of the accumulators, held motion,
// scan lock and timer computes the result of every item. Each returned item
// is checked field by field against the oldest prediction. Both channels
// idle at random.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// One line of the directed stimulus: either a new release period or an item.
	typedef struct {
		bit                new_period;
		logic [15:0]       period;
		mmlb_pkg::event_t  ev;
		bit                typed;
		mmlb_pkg::result_t want;
	} plan_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              event_valid = 1'b0;
	mmlb_pkg::event_t  event_item = '0;
	logic              result_stall = 1'b0;
	logic              cfg_valid = 1'b0;
	logic [15:0]       cfg_data = '0;
	logic              event_stall;
	logic              result_valid;
	mmlb_pkg::result_t result_item;
	logic              cfg_ready;

	mouse_motion_latch_bridge u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.event_valid  (event_valid),
		.event_stall  (event_stall),
		.event_item   (event_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	bit                calm;
	int                mismatches;
	mmlb_pkg::result_t pending_reports[$];
	mmlb_pkg::result_t oldest;
	plan_row_t         plan[$];

	// Predicted state of the bridge.
	logic [15:0] sum_x, sum_y, kept_x, kept_y;
	logic [15:0] us_count, hold_period;
	logic [7:0]  btn_live, btn_kept;
	logic        locked, scanned;
	logic [31:0] word_now;

	// Host word built from the held values: tag, buttons, low bytes of ~x>>1, ~y>>1.
	function automatic logic [31:0] host_word();
		logic [15:0] nx;
		logic [15:0] ny;
		nx = ~kept_x;
		ny = ~kept_y;
		return {mmlb_pkg::WORD_TAG, btn_kept, 8'(nx >> 1), 8'(ny >> 1)};
	endfunction

	// Advances the predicted state by one item and returns its result.
	function automatic mmlb_pkg::result_t next_host_result(input mmlb_pkg::event_t e);
		mmlb_pkg::result_t r;
		r.push_now = 1'b0;
		r.report_word = word_now;
		unique case (e.command)
			mmlb_pkg::CMD_REPORT: begin
				sum_x = sum_x + {{8{e.move_x[7]}}, e.move_x};
				sum_y = sum_y + {{8{e.move_y[7]}}, e.move_y};
				btn_live = e.button_bits;
				if (!locked) begin
					kept_x = sum_x;
					kept_y = sum_y;
					btn_kept = btn_live;
					word_now = host_word();
				end
				r.report_word = word_now;
			end
			mmlb_pkg::CMD_LATCH: begin
				if (!locked) begin
					locked = 1'b1;
					scanned = 1'b1;
					r.push_now = 1'b1;
					us_count = '0;
				end
			end
			mmlb_pkg::CMD_TICK: begin
				if (us_count != mmlb_pkg::ELAPSED_MAX)
					us_count = us_count + 16'd1;
				if (us_count > hold_period) begin
					r.report_word = host_word();
					r.push_now = 1'b1;
					// After a scan the consumed motion leaves the accumulators.
					if (scanned) begin
						sum_x = sum_x - kept_x;
						sum_y = sum_y - kept_y;
						kept_x = '0;
						kept_y = '0;
						btn_kept = btn_live;
						scanned = 1'b0;
					end
					word_now = host_word();
					locked = 1'b0;
					us_count = '0;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic plan_row_t row(input logic [1:0] c, input logic [7:0] b,
		input logic [7:0] x, input logic [7:0] y, input bit typed,
		input logic [31:0] w, input logic p);
		plan_row_t r;
		r.new_period = 1'b0;
		r.period = '0;
		r.ev.command = c;
		r.ev.button_bits = b;
		r.ev.move_x = x;
		r.ev.move_y = y;
		r.typed = typed;
		r.want.report_word = w;
		r.want.push_now = p;
		return r;
	endfunction

	function automatic plan_row_t period_row(input logic [15:0] p);
		plan_row_t r;
		r = row(mmlb_pkg::CMD_NONE, 8'h00, 8'h00, 8'h00, 1'b0, '0, 1'b0);
		r.new_period = 1'b1;
		r.period = p;
		return r;
	endfunction

	// Deltas lean toward the extremes and the values around zero.
	function automatic logic [7:0] rand_delta();
		case ($urandom_range(0, 7))
			0: return 8'h80;
			1: return 8'h7F;
			2: return 8'h00;
			3: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic mmlb_pkg::event_t make_item(input logic [1:0] c);
		mmlb_pkg::event_t e;
		e.command = c;
		e.button_bits = 8'($urandom);
		e.move_x = rand_delta();
		e.move_y = rand_delta();
		return e;
	endfunction

	// Offers one item, with random idle cycles first, and waits until it is taken.
	task automatic send_event(input mmlb_pkg::event_t e, input bit typed,
		input mmlb_pkg::result_t want);
		mmlb_pkg::result_t predicted;
		while (!calm && $urandom_range(0, 99) < 6) begin
			event_valid <= 1'b0;
			@(posedge clk);
		end
		predicted = next_host_result(e);
		pending_reports.push_back(typed ? want : predicted);
		event_valid <= 1'b1;
		event_item <= e;
		do @(posedge clk); while (event_stall);
	endtask

	// Writes the release period once every outstanding result has come back.
	task automatic set_period(input logic [15:0] p);
		event_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= p;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		hold_period = p;
	endtask

	// Result side: random stall, and a check of every item taken.
	always @(posedge clk) begin
		result_stall <= !calm && ($urandom_range(0, 99) < 6);
		if (arst_n && result_valid && !result_stall) begin
			if (pending_reports.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected item: expected none, actual word %h push %b",
					$time, result_item.report_word, result_item.push_now);
			end else begin
				oldest = pending_reports.pop_front();
				if (result_item.report_word !== oldest.report_word) begin
					mismatches++;
					$display("%0t: report_word: expected %h, actual %h",
						$time, oldest.report_word, result_item.report_word);
				end
				if (result_item.push_now !== oldest.push_now) begin
					mismatches++;
					$display("%0t: push_now: expected %b, actual %b",
						$time, oldest.push_now, result_item.push_now);
				end
			end
		end
	end

	initial begin
		logic [15:0] phase_periods [6];
		int          phase_items;
		int          pick;
		int          reps;
		int          ticks;

		sum_x = '0;
		sum_y = '0;
		kept_x = '0;
		kept_y = '0;
		us_count = '0;
		hold_period = mmlb_pkg::PERIOD_RESET;
		btn_live = mmlb_pkg::BUTTONS_RESET;
		btn_kept = mmlb_pkg::BUTTONS_RESET;
		locked = 1'b0;
		scanned = 1'b0;
		word_now = 32'h2FFFFFFF;
		calm = 1'b0;
		mismatches = 0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: reset values, delta extremes, relock, periods 1 and 0.
		plan.push_back(row(mmlb_pkg::CMD_NONE, 8'hFF, 8'hFF, 8'hFF, 1'b1,
			32'h2FFFFFFF, 1'b0));
		plan.push_back(row(mmlb_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b1,
			32'h2FFFFFFF, 1'b0));
		plan.push_back(row(mmlb_pkg::CMD_REPORT, 8'h00, 8'h7F, 8'h80, 1'b1,
			32'h2F00C03F, 1'b0));
		plan.push_back(row(mmlb_pkg::CMD_REPORT, 8'hFF, 8'h80, 8'h7F, 1'b1,
			32'h2FFF0000, 1'b0));
		plan.push_back(row(mmlb_pkg::CMD_LATCH, 8'h00, 8'h00, 8'h00, 1'b1,
			32'h2FFF0000, 1'b1));
		plan.push_back(row(mmlb_pkg::CMD_LATCH, 8'hFF, 8'hFF, 8'hFF, 1'b1,
			32'h2FFF0000, 1'b0));
		plan.push_back(row(mmlb_pkg::CMD_REPORT, 8'h12, 8'h05, 8'hFD, 1'b0, '0, 1'b0));
		plan.push_back(row(mmlb_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, '0, 1'b0));
		plan.push_back(row(mmlb_pkg::CMD_NONE, 8'h5A, 8'h33, 8'hCC, 1'b0, '0, 1'b0));
		plan.push_back(period_row(16'd1));
		plan.push_back(row(mmlb_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, '0, 1'b0));
		plan.push_back(row(mmlb_pkg::CMD_REPORT, 8'h80, 8'h01, 8'h01, 1'b0, '0, 1'b0));
		plan.push_back(row(mmlb_pkg::CMD_LATCH, 8'h00, 8'h00, 8'h00, 1'b0, '0, 1'b0));
		plan.push_back(row(mmlb_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, '0, 1'b0));
		plan.push_back(row(mmlb_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, '0, 1'b0));
		plan.push_back(row(mmlb_pkg::CMD_REPORT, 8'h7E, 8'h80, 8'h80, 1'b0, '0, 1'b0));
		plan.push_back(period_row(16'd0));
		plan.push_back(row(mmlb_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, '0, 1'b0));
		plan.push_back(row(mmlb_pkg::CMD_LATCH, 8'h00, 8'h00, 8'h00, 1'b0, '0, 1'b0));
		plan.push_back(row(mmlb_pkg::CMD_REPORT, 8'h01, 8'h7F, 8'h7F, 1'b0, '0, 1'b0));
		plan.push_back(row(mmlb_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, '0, 1'b0));
		plan.push_back(row(mmlb_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, '0, 1'b0));
		foreach (plan[i]) begin
			if (plan[i].new_period)
				set_period(plan[i].period);
			else
				send_event(plan[i].ev, plan[i].typed, plan[i].want);
		end

		// Random phases: mostly report, latch, tick scans (to release if period <= 64).
		phase_periods = '{16'd1, 16'd0, 16'($urandom_range(2, 9)),
			16'($urandom_range(10, 40)), 16'd65534, 16'd2};
		foreach (phase_periods[p]) begin
			set_period(phase_periods[p]);
			calm = (p == 3);
			phase_items = 0;
			while (phase_items < 85) begin
				pick = $urandom_range(0, 9);
				if (pick < 7) begin
					reps = $urandom_range(0, 4);
					repeat (reps)
						send_event(make_item(mmlb_pkg::CMD_REPORT), 1'b0, '0);
					send_event(make_item(mmlb_pkg::CMD_LATCH), 1'b0, '0);
					ticks = (phase_periods[p] > 64) ? $urandom_range(1, 20)
						: phase_periods[p] + 1;
					phase_items += reps + 1 + ticks;
					repeat (ticks) begin
						if ($urandom_range(0, 3) == 0) begin
							send_event(make_item(mmlb_pkg::CMD_REPORT), 1'b0, '0);
							phase_items++;
						end
						send_event(make_item(mmlb_pkg::CMD_TICK), 1'b0, '0);
					end
				end else if (pick < 9) begin
					send_event(make_item(2'($urandom_range(0, 3))), 1'b0, '0);
					phase_items++;
				end else begin
					// Broken scan: a second latch and too few ticks to release.
					send_event(make_item(mmlb_pkg::CMD_LATCH), 1'b0, '0);
					send_event(make_item(mmlb_pkg::CMD_LATCH), 1'b0, '0);
					ticks = $urandom_range(0, (phase_periods[p] > 10) ? 10 : phase_periods[p]);
					phase_items += 2 + ticks;
					repeat (ticks)
						send_event(make_item(mmlb_pkg::CMD_TICK), 1'b0, '0);
				end
			end
		end
		calm = 1'b0;

		event_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/mmlb_pkg.sv
hw/rtl/mouse_motion_latch_bridge.sv
hw/rtl/mmlb_checker.sv
dv/tb_top.sv
